>>> hw/rtl/bcu_pkg.sv
// Package for the binomial coefficient unit: widths, sequencer states and
// divider handshake types. No dependencies.
`timescale 1ns / 1ps

package bcu_pkg;

  localparam int N_BITS = 16;
  localparam int DW     = 64;
  localparam int COEF_W = 63;
  localparam int PW     = DW + N_BITS;
  localparam int CNT_W  = $clog2(DW + 1);
  localparam int MCNT_W = $clog2(N_BITS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_STEP,
    S_GCD,
    S_GCD_W,
    S_DIVI,
    S_DIVI_W,
    S_DIVJ,
    S_DIVJ_W,
    S_DIVR,
    S_DIVR_W,
    S_MUL,
    S_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic wide;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic busy;
  } div_rsp_t;

endpackage

>>> hw/rtl/bcu_ifs.sv
// Valid/ready channel interfaces for the binomial coefficient unit.
// Depends on bcu_pkg for field widths.
`timescale 1ns / 1ps

interface bcu_in_if;
  logic                       valid;
  logic                       ready;
  logic [bcu_pkg::N_BITS-1:0] n;
  logic [bcu_pkg::N_BITS-1:0] k;

  modport source (output valid, output n, output k, input ready);
  modport sink   (input valid, input n, input k, output ready);
endinterface

interface bcu_out_if;
  logic                       valid;
  logic                       ready;
  logic [bcu_pkg::COEF_W-1:0] coefficient;
  logic                       overflow;
  logic                       invalid;

  modport source (output valid, output coefficient, output overflow, output invalid,
                  input ready);
  modport sink   (input valid, input coefficient, input overflow, input invalid,
                  output ready);
endinterface

>>> hw/rtl/bcu_div.sv
// Shared restoring divider, one quotient bit per cycle, narrow or wide dividend.
// Depends on bcu_pkg.
`timescale 1ns / 1ps

module bcu_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bcu_pkg::div_req_t          req,
  input  logic [bcu_pkg::DW-1:0]     dividend,
  input  logic [bcu_pkg::N_BITS-1:0] divisor,
  output bcu_pkg::div_rsp_t          rsp,
  output logic [bcu_pkg::DW-1:0]     quotient,
  output logic [bcu_pkg::N_BITS-1:0] remainder
);
  import bcu_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DW-1:0]     quo_r;
  logic [N_BITS-1:0] rem_r;
  logic [N_BITS-1:0] dvs_r;
  logic [N_BITS:0]   rem_sh;
  logic [N_BITS:0]   rem_dif;
  logic              qbit;

  assign rem_sh  = {rem_r, quo_r[DW-1]};
  assign rem_dif = rem_sh - {1'b0, dvs_r};
  assign qbit    = (rem_sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.wide ? CNT_W'(DW) : CNT_W'(N_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.wide ? dividend : {dividend[N_BITS-1:0], {(DW-N_BITS){1'b0}}};
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], qbit};
      rem_r <= qbit ? rem_dif[N_BITS-1:0] : rem_sh[N_BITS-1:0];
    end
  end

  assign rsp.done  = done_r;
  assign rsp.busy  = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("divider started while busy");
  a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == CNT_W'(1) && !req.start) |=> done_r)
    else $error("divider missed done");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
`endif

endmodule

>>> hw/rtl/exact_binomial_coefficient_unit.sv
// Top level of the exact binomial coefficient unit: sequencer, gcd/product loop.
// Depends on bcu_pkg, bcu_ifs (channels) and bcu_div (shared divider).
//
//   channel   dir  beat payload                        handshake
//   in_bus    in   n, k (16 b each)                    valid/ready
//   out_bus   out  coefficient (63 b), overflow, inv.  valid/ready
//
// Shortcut items (k > n, k in {0, 1, n-1, n}) skip the loop; S_DONE loads the output register once it is free.
// Loop step: S_STEP, Euclid gcd g of i = n-k+j and j, then i/g, j/g, r/(j/g) (wide), a shift-add multiply
// by i/g and a check; all divisions share bcu_div. Loop items run steps j = 1..min(k, n-k) before the
// done state, fewer when overflow ends the loop. in_bus.ready is high only in idle, after the load.
// Synchronous active-low reset returns to idle with no result pending.
// A stalled result holds in the output register; the next item runs but waits to finish.
`timescale 1ns / 1ps

module exact_binomial_coefficient_unit (
  input  logic      clk,
  input  logic      rst_n,
  bcu_in_if.sink    in_bus,
  bcu_out_if.source out_bus
);
  import bcu_pkg::*;

  state_t            state_r, state_nxt;
  logic [N_BITS-1:0] n_r, k_r, j_r, i_r;
  logic [N_BITS-1:0] a_r, b_r, id_r, jd_r, idsh_r;
  logic [COEF_W-1:0] r_r, q_r;
  logic [PW-1:0]     acc_r;
  logic [MCNT_W-1:0] mcnt_r;
  logic [COEF_W-1:0] res_coef_r;
  logic              res_ovf_r, res_inv_r;
  logic              out_valid_r;
  logic [COEF_W-1:0] out_coef_r;
  logic              out_ovf_r, out_inv_r;

  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [DW-1:0]     div_dividend, div_quo;
  logic [N_BITS-1:0] div_divisor, div_rem;

  logic              in_fire, out_load, acc_ovf, shortcut;
  logic [N_BITS-1:0] k_red;

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign acc_ovf  = |acc_r[PW-1:COEF_W];
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_bus.ready);
  assign shortcut = (in_bus.k > in_bus.n) || (in_bus.k == '0) || (in_bus.k == in_bus.n)
                    || (in_bus.k == N_BITS'(1)) || (in_bus.k == in_bus.n - 1'b1);
  assign k_red    = (in_bus.k > (in_bus.n >> 1)) ? in_bus.n - in_bus.k : in_bus.k;

  bcu_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .rsp       (div_rsp),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_fire) state_nxt = shortcut ? S_DONE : S_STEP;
      S_STEP:   state_nxt = S_GCD;
      S_GCD:    state_nxt = (b_r == '0) ? S_DIVI : S_GCD_W;
      S_GCD_W:  if (div_rsp.done) state_nxt = S_GCD;
      S_DIVI:   state_nxt = S_DIVI_W;
      S_DIVI_W: if (div_rsp.done) state_nxt = S_DIVJ;
      S_DIVJ:   state_nxt = S_DIVJ_W;
      S_DIVJ_W: if (div_rsp.done) state_nxt = S_DIVR;
      S_DIVR:   state_nxt = S_DIVR_W;
      S_DIVR_W: if (div_rsp.done) state_nxt = S_MUL;
      S_MUL:    if (mcnt_r == MCNT_W'(1)) state_nxt = S_CHK;
      S_CHK:    state_nxt = (acc_ovf || j_r == k_r) ? S_DONE : S_STEP;
      S_DONE:   if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_bus.ready  = 1'b0;
    div_req.start = 1'b0;
    div_req.wide  = 1'b0;
    div_dividend  = {{(DW-N_BITS){1'b0}}, a_r};
    div_divisor   = b_r;
    unique case (state_r)
      S_IDLE: in_bus.ready = 1'b1;
      S_GCD:  div_req.start = (b_r != '0);
      S_DIVI: begin
        div_req.start = 1'b1;
        div_dividend  = {{(DW-N_BITS){1'b0}}, i_r};
        div_divisor   = a_r;
      end
      S_DIVJ: begin
        div_req.start = 1'b1;
        div_dividend  = {{(DW-N_BITS){1'b0}}, j_r};
        div_divisor   = a_r;
      end
      S_DIVR: begin
        div_req.start = 1'b1;
        div_req.wide  = 1'b1;
        div_dividend  = {{(DW-COEF_W){1'b0}}, r_r};
        div_divisor   = jd_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_coef_r <= res_coef_r;
      out_ovf_r  <= res_ovf_r;
      out_inv_r  <= res_inv_r;
    end
    unique case (state_r)
      S_IDLE: if (in_fire) begin
        n_r        <= in_bus.n;
        k_r        <= k_red;
        j_r        <= N_BITS'(1);
        r_r        <= COEF_W'(1);
        res_ovf_r  <= 1'b0;
        res_inv_r  <= (in_bus.k > in_bus.n);
        if (in_bus.k > in_bus.n) begin
          res_coef_r <= '0;
        end else if (in_bus.k == '0 || in_bus.k == in_bus.n) begin
          res_coef_r <= COEF_W'(1);
        end else begin
          res_coef_r <= {{(COEF_W-N_BITS){1'b0}}, in_bus.n};
        end
      end
      S_STEP: begin
        i_r <= n_r - k_r + j_r;
        a_r <= n_r - k_r + j_r;
        b_r <= j_r;
      end
      S_GCD_W: if (div_rsp.done) begin
        a_r <= b_r;
        b_r <= div_rem;
      end
      S_DIVI_W: if (div_rsp.done) id_r <= div_quo[N_BITS-1:0];
      S_DIVJ_W: if (div_rsp.done) jd_r <= div_quo[N_BITS-1:0];
      S_DIVR_W: if (div_rsp.done) begin
        q_r    <= div_quo[COEF_W-1:0];
        acc_r  <= '0;
        idsh_r <= id_r;
        mcnt_r <= MCNT_W'(N_BITS);
      end
      S_MUL: begin
        acc_r  <= {acc_r[PW-2:0], 1'b0}
                  + (idsh_r[N_BITS-1] ? {{(PW-COEF_W){1'b0}}, q_r} : '0);
        idsh_r <= {idsh_r[N_BITS-2:0], 1'b0};
        mcnt_r <= mcnt_r - 1'b1;
      end
      S_CHK: begin
        r_r <= acc_r[COEF_W-1:0];
        j_r <= j_r + 1'b1;
        if (acc_ovf) begin
          res_coef_r <= '0;
          res_ovf_r  <= 1'b1;
        end else if (j_r == k_r) begin
          res_coef_r <= acc_r[COEF_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.coefficient = out_coef_r;
  assign out_bus.overflow    = out_ovf_r;
  assign out_bus.invalid     = out_inv_r;

`ifndef SYNTHESIS
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> !(out_bus.overflow && out_bus.invalid))
    else $error("overflow and invalid both set");
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && (out_bus.overflow || out_bus.invalid)) |-> out_bus.coefficient == '0)
    else $error("flagged result not zero");
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP) |-> (j_r != '0 && j_r <= k_r))
    else $error("loop index out of range");
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GCD && b_r == '0) |-> a_r != '0)
    else $error("zero gcd");
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVI || state_r == S_DIVJ || state_r == S_DIVR) |-> !div_rsp.busy)
    else $error("divider busy at start");
`endif

endmodule
